FILE: rtl/hrp_pkg.sv
// ============================================================================
// hrp_pkg
// Shared types and constants for the hex record parser.
// ============================================================================
`default_nettype none

package hrp_pkg;

    localparam logic [7:0] COLON_CHAR   = 8'h3A;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] NUL_CHAR     = 8'h00;
    localparam logic [8:0] FRAME_BYTES  = 9'd5;
    localparam logic [8:0] INDEX_MAX    = 9'd511;

    localparam int TDATA_W = 40;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_LENGTH   = 3'd2,
        ST_CHECKSUM = 3'd3,
        ST_TYPE     = 3'd4,
        ST_NOSTART  = 3'd5
    } hrp_status_t;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_STATUS = 1'b1
    } hrp_kind_t;

    typedef struct packed {
        hrp_kind_t   kind;
        logic [7:0]  data_byte;
        logic [7:0]  byte_offset;
        logic [15:0] load_address;
        hrp_status_t status;
        logic        last;
    } hrp_result_t;

endpackage

`default_nettype wire

FILE: rtl/hrp_parser.sv
// ============================================================================
// hrp_parser
// Record state and combinational decode of one character into at most one result.
// ============================================================================
`default_nettype none

module hrp_parser (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                accept,
    input  wire logic [7:0]          char_in,
    output logic                     res_valid,
    output hrp_pkg::hrp_result_t     res
);
    import hrp_pkg::*;

    logic        in_record_reg, in_record_next;
    logic [3:0]  high_nibble_reg, high_nibble_next;
    logic        nibble_pending_reg, nibble_pending_next;
    logic [8:0]  byte_index_reg, byte_index_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [7:0]  record_count_reg, record_count_next;
    logic [15:0] record_address_reg, record_address_next;
    logic [7:0]  record_type_reg, record_type_next;

    logic        is_hex;
    logic [3:0]  digit;
    logic [7:0]  value;
    logic [8:0]  count_ext;

    always_comb
    begin
        is_hex = 1'b1;
        digit  = 4'd0;
        if (char_in >= 8'h30 && char_in <= 8'h39)
        begin
            digit = 4'(char_in - 8'h30);
        end
        else if (char_in >= 8'h61 && char_in <= 8'h66)
        begin
            digit = 4'(char_in - 8'h57);
        end
        else if (char_in >= 8'h41 && char_in <= 8'h46)
        begin
            digit = 4'(char_in - 8'h37);
        end
        else
        begin
            is_hex = 1'b0;
        end
    end

    assign value     = {high_nibble_reg, digit};
    assign count_ext = {1'b0, record_count_reg};

    always_comb
    begin
        in_record_next      = in_record_reg;
        high_nibble_next    = high_nibble_reg;
        nibble_pending_next = nibble_pending_reg;
        byte_index_next     = byte_index_reg;
        running_sum_next    = running_sum_reg;
        record_count_next   = record_count_reg;
        record_address_next = record_address_reg;
        record_type_next    = record_type_reg;

        res_valid        = 1'b0;
        res.kind         = KIND_DATA;
        res.data_byte    = 8'd0;
        res.byte_offset  = 8'd0;
        res.load_address = record_address_reg;
        res.status       = ST_OK;
        res.last         = 1'b0;

        if (!in_record_reg)
        begin
            if (char_in == COLON_CHAR)
            begin
                in_record_next      = 1'b1;
                high_nibble_next    = 4'd0;
                nibble_pending_next = 1'b0;
                byte_index_next     = 9'd0;
                running_sum_next    = 8'd0;
                record_count_next   = 8'd0;
                record_address_next = 16'd0;
                record_type_next    = 8'd0;
            end
            else if (char_in == NUL_CHAR)
            begin
                res_valid        = 1'b1;
                res.kind         = KIND_STATUS;
                res.load_address = 16'd0;
                res.status       = ST_NOSTART;
                res.last         = 1'b1;
            end
        end
        else if (char_in == NEWLINE_CHAR || char_in == NUL_CHAR)
        begin
            res_valid = 1'b1;
            res.kind  = KIND_STATUS;
            res.last  = 1'b1;
            priority if (byte_index_reg == 9'd0)
                res.status = ST_EMPTY;
            else if (byte_index_reg != count_ext + FRAME_BYTES)
                res.status = ST_LENGTH;
            else if (running_sum_reg != 8'd0)
                res.status = ST_CHECKSUM;
            else if (record_type_reg != 8'd0)
                res.status = ST_TYPE;
            else
                res.status = ST_OK;
            in_record_next      = 1'b0;
            high_nibble_next    = 4'd0;
            nibble_pending_next = 1'b0;
            byte_index_next     = 9'd0;
            running_sum_next    = 8'd0;
            record_count_next   = 8'd0;
            record_address_next = 16'd0;
            record_type_next    = 8'd0;
        end
        else if (is_hex)
        begin
            if (!nibble_pending_reg)
            begin
                high_nibble_next    = digit;
                nibble_pending_next = 1'b1;
            end
            else
            begin
                high_nibble_next    = 4'd0;
                nibble_pending_next = 1'b0;
                running_sum_next    = running_sum_reg + value;
                priority if (byte_index_reg == 9'd0)
                    record_count_next = value;
                else if (byte_index_reg == 9'd1)
                    record_address_next = {value, record_address_reg[7:0]};
                else if (byte_index_reg == 9'd2)
                    record_address_next = {record_address_reg[15:8], value};
                else if (byte_index_reg == 9'd3)
                    record_type_next = value;
                else if (byte_index_reg <= count_ext + 9'd3)
                begin
                    res_valid       = 1'b1;
                    res.data_byte   = value;
                    res.byte_offset = 8'(byte_index_reg - 9'd4);
                end
                if (byte_index_reg != INDEX_MAX)
                    byte_index_next = byte_index_reg + 9'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_record_reg      <= 1'b0;
            high_nibble_reg    <= 4'd0;
            nibble_pending_reg <= 1'b0;
            byte_index_reg     <= 9'd0;
            running_sum_reg    <= 8'd0;
            record_count_reg   <= 8'd0;
            record_address_reg <= 16'd0;
            record_type_reg    <= 8'd0;
        end
        else if (accept)
        begin
            in_record_reg      <= in_record_next;
            high_nibble_reg    <= high_nibble_next;
            nibble_pending_reg <= nibble_pending_next;
            byte_index_reg     <= byte_index_next;
            running_sum_reg    <= running_sum_next;
            record_count_reg   <= record_count_next;
            record_address_reg <= record_address_next;
            record_type_reg    <= record_type_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hrp_skid.sv
// ============================================================================
// hrp_skid
// Output register with a skid stage; ready toward the parser is registered.
// ============================================================================
`default_nettype none

module hrp_skid (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire hrp_pkg::hrp_result_t in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output hrp_pkg::hrp_result_t     out_data
);
    import hrp_pkg::*;

    logic        out_valid_reg;
    logic        skid_valid_reg;
    hrp_result_t out_data_reg;
    hrp_result_t skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !out_ready)
        begin
            if (in_valid && !skid_valid_reg)
                skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !out_ready)
        begin
            if (in_valid && !skid_valid_reg)
                skid_data_reg <= in_data;
        end
        else if (skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (in_valid)
        begin
            out_data_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hex_record_parser_core.sv
// ============================================================================
// hex_record_parser_core
// Hex record text parser: one character in, data bytes and record status out.
// ============================================================================
// Accepts one ASCII character per clock while s_tready is high, and registers
// the result that an accepted character causes. The record state is updated on
// each accepted character; results pass through an output register backed
// by a skid stage, so s_tready stays high while downstream takes results and
// drops only after two results are held. Data results (m_tuser = 0) carry each
// payload byte with its offset and the record address; the status result
// (m_tuser = 1, m_tlast = 1) closes a record on newline or NUL, and a NUL seen
// outside a record gives a no-start status. Discard the data of a record whose
// status is not ok.
`default_nettype none

module hex_record_parser_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_in
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [hrp_pkg::TDATA_W-1:0] m_tdata,
                                        // [7:0] data_byte, [15:8] byte_offset,
                                        // [31:16] load_address, [34:32] status, [39:35] zero
    output logic             m_tuser,   // [0] kind
    output logic             m_tlast
);
    import hrp_pkg::*;

    logic        accept;
    logic        res_valid;
    hrp_result_t res;
    hrp_result_t out_res;

    assign accept = s_tvalid && s_tready;

    hrp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_in   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    hrp_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept && res_valid),
        .in_ready  (s_tready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {5'd0, out_res.status, out_res.load_address,
                      out_res.byte_offset, out_res.data_byte};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

`ifndef SYNTH
    a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result held");

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == m_tlast))
        else $error("result kind and last disagree");

    a_data_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[34:32] == ST_OK))
        else $error("data result carries a status");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[34:32] <= ST_NOSTART && m_tdata[39:35] == 5'd0))
        else $error("status code out of range");
`endif

endmodule

`default_nettype wire

FILE: tb/hex_scoreboard_pkg.sv
// ============================================================================
// hex_scoreboard_pkg
// Scoreboard for the hex record parser: tracks record state per character,
// queues the data bytes and record statuses it should see, and checks each
// result transaction against the oldest one queued.
// ============================================================================
package hex_scoreboard_pkg;

    import hrp_pkg::*;

    class hex_scoreboard;

        bit          in_rec;
        logic [3:0]  hi_nib;
        bit          nib_held;
        logic [8:0]  idx;
        logic [7:0]  sum;
        logic [7:0]  count_field;
        logic [15:0] addr;
        logic [7:0]  rec_type;

        hrp_result_t awaited_q[$];
        int          errors;
        int          data_seen;
        int          status_seen;

        function new();
            in_rec      = 1'b0;
            errors      = 0;
            data_seen   = 0;
            status_seen = 0;
            clear_record();
        endfunction

        function void clear_record();
            hi_nib      = '0;
            nib_held    = 1'b0;
            idx         = '0;
            sum         = '0;
            count_field = '0;
            addr        = '0;
            rec_type    = '0;
        endfunction

        function int nibble_of(logic [7:0] ch);
            if (ch >= "0" && ch <= "9") return int'(ch - "0");
            if (ch >= "a" && ch <= "f") return int'(ch - "a") + 10;
            if (ch >= "A" && ch <= "F") return int'(ch - "A") + 10;
            return -1;
        endfunction

        function hrp_result_t status_result(hrp_status_t st, logic [15:0] a);
            hrp_result_t r;
            r.kind         = KIND_STATUS;
            r.data_byte    = '0;
            r.byte_offset  = '0;
            r.load_address = a;
            r.status       = st;
            r.last         = 1'b1;
            return r;
        endfunction

        function void note_char(logic [7:0] ch);
            hrp_result_t r;
            hrp_status_t st;
            logic [7:0]  value;
            int          nib;
            if (!in_rec) begin
                if (ch == COLON_CHAR) begin
                    in_rec = 1'b1;
                    clear_record();
                end
                else if (ch == NUL_CHAR) begin
                    awaited_q.push_back(status_result(ST_NOSTART, 16'h0000));
                end
                return;
            end
            if (ch == NEWLINE_CHAR || ch == NUL_CHAR) begin
                if (idx == 0)
                    st = ST_EMPTY;
                else if (int'(idx) != int'(count_field) + int'(FRAME_BYTES))
                    st = ST_LENGTH;
                else if (sum != 8'h00)
                    st = ST_CHECKSUM;
                else if (rec_type != 8'h00)
                    st = ST_TYPE;
                else
                    st = ST_OK;
                awaited_q.push_back(status_result(st, addr));
                in_rec = 1'b0;
                clear_record();
                return;
            end
            nib = nibble_of(ch);
            if (nib < 0)
                return;
            if (!nib_held) begin
                hi_nib   = nib[3:0];
                nib_held = 1'b1;
                return;
            end
            value    = {hi_nib, nib[3:0]};
            nib_held = 1'b0;
            hi_nib   = '0;
            sum      = sum + value;
            case (idx)
                9'd0: count_field = value;
                9'd1: addr[15:8]  = value;
                9'd2: addr[7:0]   = value;
                9'd3: rec_type    = value;
                default:
                begin
                    if (int'(idx) <= 3 + int'(count_field)) begin
                        r.kind         = KIND_DATA;
                        r.data_byte    = value;
                        r.byte_offset  = 8'(idx - 9'd4);
                        r.load_address = addr;
                        r.status       = ST_OK;
                        r.last         = 1'b0;
                        awaited_q.push_back(r);
                    end
                end
            endcase
            if (idx < INDEX_MAX)
                idx = idx + 9'd1;
        endfunction

        task report(string what);
            $display("[%0t] %s", $time, what);
            errors++;
        endtask

        task check_result(hrp_result_t got);
            hrp_result_t want;
            if (awaited_q.size() == 0) begin
                report($sformatf("result with nothing awaited: %p", got));
                return;
            end
            want = awaited_q.pop_front();
            if (want.kind == KIND_DATA)
                data_seen++;
            else
                status_seen++;
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, wanted %0d", got.kind, want.kind));
            if (got.data_byte !== want.data_byte)
                report($sformatf("data_byte %h, wanted %h", got.data_byte, want.data_byte));
            if (got.byte_offset !== want.byte_offset)
                report($sformatf("byte_offset %0d, wanted %0d",
                                 got.byte_offset, want.byte_offset));
            if (got.load_address !== want.load_address)
                report($sformatf("load_address %h, wanted %h",
                                 got.load_address, want.load_address));
            if (got.status !== want.status)
                report($sformatf("status %0d, wanted %0d", got.status, want.status));
            if (got.last !== want.last)
                report($sformatf("last %0d, wanted %0d", got.last, want.last));
        endtask

    endclass

endpackage

FILE: tb/tb_top.sv
// ============================================================================
// tb_top
// Streaming testbench for hex_record_parser_core.
// Feeds directed corner records, then random well-formed and broken records
// mixed with line noise, under random gaps and stalls on both sides; every
// output transaction is checked against the scoreboard's prediction.
// ============================================================================
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import hrp_pkg::*;
    import hex_scoreboard_pkg::*;

    localparam int RANDOM_CHARS = 380;
    localparam int CYCLE_LIMIT  = 500000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    hex_scoreboard sb = new();
    bit            calm = 1'b0;
    int            chars_sent = 0;
    int            stall_left = 0;
    int            cycles = 0;

    hex_record_parser_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        hrp_result_t got;
        if (rst_n && m_tvalid && m_tready) begin
            got.kind         = hrp_kind_t'(m_tuser);
            got.data_byte    = m_tdata[7:0];
            got.byte_offset  = m_tdata[15:8];
            got.load_address = m_tdata[31:16];
            got.status       = hrp_status_t'(m_tdata[34:32]);
            got.last         = m_tlast;
            sb.check_result(got);
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else begin
            m_tready   <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    task automatic send_char(input logic [7:0] ch);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_char(ch);
        chars_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.awaited_q.size() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 4'd10) return 8'h30 + 8'(nib);
        if ($urandom_range(0, 1)) return 8'h41 + 8'(nib) - 8'd10;
        return 8'h61 + 8'(nib) - 8'd10;
    endfunction

    function automatic logic [7:0] filler_char();
        logic [7:0] ch;
        ch = 8'($urandom_range(0, 255));
        while (sb.nibble_of(ch) >= 0 || ch == NEWLINE_CHAR || ch == NUL_CHAR)
            ch = 8'($urandom_range(0, 255));
        return ch;
    endfunction

    // flaw: 0 none, 1 nonzero type, 2 bad checksum, 3 excess bytes,
    // 4 checksum missing, 5 count disagrees, 6 stray characters of any value
    task automatic send_record(input int ndata, input int flaw, input int n_excess);
        logic [7:0] rec[$];
        logic [7:0] total;
        int         k;
        rec.push_back(flaw == 5 ? 8'(ndata + $urandom_range(1, 3)) : 8'(ndata));
        rec.push_back(8'($urandom_range(0, 255)));
        rec.push_back(8'($urandom_range(0, 255)));
        rec.push_back(flaw == 1 ? 8'($urandom_range(1, 255)) : 8'h00);
        for (k = 0; k < ndata; k++)
            rec.push_back(8'($urandom_range(0, 255)));
        total = '0;
        foreach (rec[i])
            total = total + rec[i];
        rec.push_back(flaw == 2 ? (8'h00 - total) ^ 8'($urandom_range(1, 255))
                                : 8'h00 - total);
        if (flaw == 3)
            for (k = 0; k < n_excess; k++)
                rec.push_back(8'($urandom_range(0, 255)));
        if (flaw == 4)
            void'(rec.pop_back());
        send_char(COLON_CHAR);
        foreach (rec[i]) begin
            send_char(hex_char(rec[i][7:4]));
            if ($urandom_range(0, 7) == 0)
                send_char(filler_char());
            if (flaw == 6 && $urandom_range(0, 9) == 0)
                send_char(8'($urandom_range(0, 255)));
            send_char(hex_char(rec[i][3:0]));
        end
        if ($urandom_range(0, 7) == 0)
            send_char(hex_char(4'($urandom_range(0, 15))));
        send_char($urandom_range(0, 3) == 0 ? NUL_CHAR : NEWLINE_CHAR);
    endtask

    initial
    begin
        string directed_rec;
        int    pick;
        int    k;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_char(NUL_CHAR);
        send_char(8'hFF);
        send_char("x");
        send_char(COLON_CHAR);
        send_char(NUL_CHAR);
        // colon inside the record, lowercase digit, odd trailing nibble
        directed_rec = ":01:000000aB54F\n";
        for (k = 0; k < directed_rec.len(); k++)
            send_char(directed_rec[k]);
        drain();

        while (chars_sent < RANDOM_CHARS + 21) begin
            calm = ($urandom_range(0, 9) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                repeat ($urandom_range(1, 4))
                    send_char(8'($urandom_range(0, 255)));
            end
            else if (pick < 75) begin
                send_record($urandom_range(0, 9) == 0 ? $urandom_range(9, 40)
                                                      : $urandom_range(0, 8), 0, 0);
            end
            else begin
                send_record($urandom_range(0, 8), $urandom_range(1, 6),
                            $urandom_range(1, 3));
            end
            if ($urandom_range(0, 19) == 0)
                drain();
        end
        calm = 1'b0;
        // full data run, then a long tail of bytes past the checksum
        send_record(8, 3, 12);

        s_tvalid <= 1'b0;
        while (sb.awaited_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d characters; checked %0d data bytes and %0d record statuses.",
                 chars_sent, sb.data_seen, sb.status_seen);
        $display("Covered noise, empty, malformed and overlong records under gaps and stalls.");
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
